/* hw/rtl/euler_rotation_matrix_top_assert.svh */
// Assertion macros for the checker file of the rotation matrix block.
// Needs nothing else; include where concurrent assertions are written.
`ifndef EULER_ROTATION_MATRIX_TOP_ASSERT_SVH
`define EULER_ROTATION_MATRIX_TOP_ASSERT_SVH

// check on every edge outside reset
`define ERM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("label failed");

// check on every edge, reset included
`define ERM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("label failed");

`endif

/* hw/rtl/erm_pkg.sv */
// Shared types, constants and the Q.31 product for the rotation matrix block.
// No dependencies.
package erm_pkg;

  localparam int LANE_STAGES  = 24;
  localparam int MERGE_STAGES = 4;
  localparam int SERIES_TERMS = 7;
  localparam logic [31:0] HALF_PI_Q31 = 32'd3373259426;
  localparam logic [31:0] ONE_Q31     = 32'h8000_0000;

  typedef struct packed {
    logic signed [32:0] s;
    logic signed [32:0] c;
  } sc_t;

  function automatic logic signed [32:0] qmul(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
    logic        neg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [32:0] m;
    neg = a[32] ^ b[32];
    ma  = a[32] ? 32'(-a) : 32'(a);
    mb  = b[32] ? 32'(-b) : 32'(b);
    p   = 64'(ma) * 64'(mb) + (64'd1 << 30);
    m   = 33'(p >> 31);
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

/* hw/rtl/erm_sincos.sv */
// One sine/cosine lane: phase fold, series over pipelined terms, quadrant map.
// Depends on erm_pkg; stage enables come from the top level.
module erm_sincos #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  logic [erm_pkg::LANE_STAGES-1:0] en,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output erm_pkg::sc_t                 sc
);
  import erm_pkg::*;

  typedef struct packed {
    logic [31:0]        x2;
    logic signed [33:0] s;
    logic signed [33:0] c;
    logic [1:0]         quad;
    logic               swap;
  } acc_t;

  logic [31:0] phase;
  logic [29:0] rr;
  logic [63:0] xp;
  logic [63:0] x2p;
  logic [31:0] x0;
  logic [1:0]  quad0;
  logic        swap0;
  acc_t        acc1;
  logic [31:0] ts1;
  logic [31:0] tc1;

  acc_t        acc_a [SERIES_TERMS];
  acc_t        acc_b [SERIES_TERMS];
  acc_t        acc_c [SERIES_TERMS];
  logic [31:0] ta_s  [SERIES_TERMS];
  logic [31:0] ta_c  [SERIES_TERMS];
  logic [31:0] nb_s  [SERIES_TERMS];
  logic [31:0] nb_c  [SERIES_TERMS];
  logic [31:0] qb_s  [SERIES_TERMS];
  logic [31:0] qb_c  [SERIES_TERMS];
  logic [31:0] tk_s  [SERIES_TERMS];
  logic [31:0] tk_c  [SERIES_TERMS];

  always_comb begin
    phase = 32'(angle) << (32 - ANGLE_BITS);
    rr    = phase[29] ? 30'(31'h4000_0000 - 31'(phase[29:0])) : phase[29:0];
    xp    = 64'(rr) * 64'(HALF_PI_Q31) + (64'd1 << 29);
    x2p   = 64'(x0) * 64'(x0) + (64'd1 << 30);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0    <= 32'(xp >> 30);
      quad0 <= phase[31:30];
      swap0 <= phase[29];
    end
    if (en[1]) begin
      acc1.x2   <= 32'(x2p >> 31);
      acc1.s    <= 34'(x0);
      acc1.c    <= 34'(ONE_Q31);
      acc1.quad <= quad0;
      acc1.swap <= swap0;
      ts1       <= x0;
      tc1       <= ONE_Q31;
    end
  end

  for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_term
    localparam int DS = (2 * k + 2) * (2 * k + 3);
    localparam int DC = (2 * k + 1) * (2 * k + 2);
    localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
    localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);
    acc_t        acc_in;
    logic [31:0] ts_in;
    logic [31:0] tc_in;
    logic [63:0] pa_s;
    logic [63:0] pa_c;
    logic [63:0] pb_s;
    logic [63:0] pb_c;
    logic [31:0] r_s;
    logic [31:0] r_c;
    logic [31:0] q_s;
    logic [31:0] q_c;

    if (k == 0) begin : g_first
      assign acc_in = acc1;
      assign ts_in  = ts1;
      assign tc_in  = tc1;
    end else begin : g_next
      assign acc_in = acc_c[k-1];
      assign ts_in  = tk_s[k-1];
      assign tc_in  = tk_c[k-1];
    end

    always_comb begin
      pa_s = 64'(ts_in) * 64'(acc_in.x2) + (64'd1 << 30);
      pa_c = 64'(tc_in) * 64'(acc_in.x2) + (64'd1 << 30);
      pb_s = 64'(ta_s[k] + 32'(DS / 2)) * 64'(MS);
      pb_c = 64'(ta_c[k] + 32'(DC / 2)) * 64'(MC);
      r_s  = nb_s[k] - qb_s[k] * 32'(DS);
      r_c  = nb_c[k] - qb_c[k] * 32'(DC);
      q_s  = qb_s[k] + 32'(r_s >= 32'(DS));
      q_c  = qb_c[k] + 32'(r_c >= 32'(DC));
    end

    always_ff @(posedge clk) begin
      if (en[2 + 3 * k]) begin
        acc_a[k] <= acc_in;
        ta_s[k]  <= 32'(pa_s >> 31);
        ta_c[k]  <= 32'(pa_c >> 31);
      end
      if (en[3 + 3 * k]) begin
        acc_b[k] <= acc_a[k];
        nb_s[k]  <= ta_s[k] + 32'(DS / 2);
        nb_c[k]  <= ta_c[k] + 32'(DC / 2);
        qb_s[k]  <= 32'(pb_s >> 32);
        qb_c[k]  <= 32'(pb_c >> 32);
      end
      if (en[4 + 3 * k]) begin
        acc_c[k].x2   <= acc_b[k].x2;
        acc_c[k].quad <= acc_b[k].quad;
        acc_c[k].swap <= acc_b[k].swap;
        tk_s[k]  <= q_s;
        tk_c[k]  <= q_c;
        if (k % 2 == 0) begin
          acc_c[k].s <= acc_b[k].s - $signed({2'b00, q_s});
          acc_c[k].c <= acc_b[k].c - $signed({2'b00, q_c});
        end else begin
          acc_c[k].s <= acc_b[k].s + $signed({2'b00, q_s});
          acc_c[k].c <= acc_b[k].c + $signed({2'b00, q_c});
        end
      end
    end
  end

  acc_t               acc_l;
  logic [31:0]        sf;
  logic [31:0]        cf;
  logic signed [32:0] ss;
  logic signed [32:0] cc;

  always_comb begin
    acc_l = acc_c[SERIES_TERMS-1];
    if (acc_l.s < 0) sf = '0;
    else if (acc_l.s > $signed({2'b00, ONE_Q31})) sf = ONE_Q31;
    else sf = acc_l.s[31:0];
    if (acc_l.c < 0) cf = '0;
    else if (acc_l.c > $signed({2'b00, ONE_Q31})) cf = ONE_Q31;
    else cf = acc_l.c[31:0];
    ss = acc_l.swap ? $signed({1'b0, cf}) : $signed({1'b0, sf});
    cc = acc_l.swap ? $signed({1'b0, sf}) : $signed({1'b0, cf});
  end

  always_ff @(posedge clk) begin
    if (en[LANE_STAGES-1]) begin
      case (acc_l.quad)
        2'd1: begin
          sc.s <= cc;
          sc.c <= -ss;
        end
        2'd2: begin
          sc.s <= -ss;
          sc.c <= -cc;
        end
        2'd3: begin
          sc.s <= -cc;
          sc.c <= ss;
        end
        default: begin
          sc.s <= ss;
          sc.c <= cc;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/erm_merge.sv */
// Merge stage: products of the three lanes' sines and cosines into R.
// Depends on erm_pkg (qmul, sc_t); stage enables come from the top level.
module erm_merge #(
  parameter int FRAC_BITS = 14
) (
  input  logic                                clk,
  input  logic [erm_pkg::MERGE_STAGES-1:0]    en,
  input  erm_pkg::sc_t                        scx,
  input  erm_pkg::sc_t                        scy,
  input  erm_pkg::sc_t                        scz,
  output logic signed [FRAC_BITS+1:0]         m [9]
);
  import erm_pkg::*;

  localparam int SH = 31 - FRAC_BITS;
  localparam logic [32:0] RND = 33'(1) << (SH - 1);
  localparam logic [32:0] LIM = 33'(1) << FRAC_BITS;

  function automatic logic signed [FRAC_BITS+1:0] to_out(input logic signed [33:0] v);
    logic                 neg;
    logic [32:0]          mag;
    logic [32:0]          mm;
    logic [FRAC_BITS+1:0] t;
    neg = v[33];
    mag = neg ? 33'(-v) : 33'(v);
    mm  = (mag + RND) >> SH;
    if (mm > LIM) mm = LIM;
    t = (FRAC_BITS + 2)'(mm);
    return neg ? -$signed(t) : $signed(t);
  endfunction

  logic signed [32:0] sxsy, cxsy, cycz, cxsz, sxsz, cysz, cxcz, sxcz, sxcy, cxcy;
  logic signed [32:0] sy1, cz1, sz1;
  logic signed [32:0] a1, a2, a4, a5;
  logic signed [32:0] b_cxsz, b_sxsz, b_cxcz, b_sxcz, b_cycz, b_cysz, b_sxcy, b_cxcy, b_sy;
  logic signed [33:0] e [9];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sxsy <= qmul(scx.s, scy.s);
      cxsy <= qmul(scx.c, scy.s);
      cycz <= qmul(scy.c, scz.c);
      cxsz <= qmul(scx.c, scz.s);
      sxsz <= qmul(scx.s, scz.s);
      cysz <= qmul(scy.c, scz.s);
      cxcz <= qmul(scx.c, scz.c);
      sxcz <= qmul(scx.s, scz.c);
      sxcy <= qmul(scx.s, scy.c);
      cxcy <= qmul(scx.c, scy.c);
      sy1  <= scy.s;
      cz1  <= scz.c;
      sz1  <= scz.s;
    end
    if (en[1]) begin
      a1     <= qmul(sxsy, cz1);
      a4     <= qmul(sxsy, sz1);
      a2     <= qmul(cxsy, cz1);
      a5     <= qmul(cxsy, sz1);
      b_cxsz <= cxsz;
      b_sxsz <= sxsz;
      b_cxcz <= cxcz;
      b_sxcz <= sxcz;
      b_cycz <= cycz;
      b_cysz <= cysz;
      b_sxcy <= sxcy;
      b_cxcy <= cxcy;
      b_sy   <= sy1;
    end
    if (en[2]) begin
      e[0] <= 34'(b_cycz);
      e[1] <= 34'(a1) - 34'(b_cxsz);
      e[2] <= 34'(a2) + 34'(b_sxsz);
      e[3] <= 34'(b_cysz);
      e[4] <= 34'(a4) + 34'(b_cxcz);
      e[5] <= 34'(a5) - 34'(b_sxcz);
      e[6] <= -34'(b_sy);
      e[7] <= 34'(b_sxcy);
      e[8] <= 34'(b_cxcy);
    end
    if (en[3]) begin
      for (int i = 0; i < 9; i++) begin
        m[i] <= to_out(e[i]);
      end
    end
  end

endmodule

/* hw/rtl/euler_rotation_matrix_top.sv */
// Top level of the Euler-angle (ZYX) rotation matrix block.
// Depends on erm_pkg, erm_sincos (three lanes) and erm_merge.
//
//   beat      signals                         direction
//   angles    angle_valid/angle_stall, x y z  into block
//   matrix    matrix_valid/matrix_stall, mRC  out of block
//
// One beat per cycle unless a stalled output backs up the pipeline; the
// sine/cosine lanes hold two fold stages, three per series term and one
// quadrant map, and the product merge follows them.
// Each stage moves on when the stage after it is empty or moving, so
// bubbles close up under a stalled output and new beats still enter.
// Synchronous reset clears stage valids only.
module euler_rotation_matrix_top #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        angle_valid,
  output logic                        angle_stall,
  input  logic signed [ANGLE_BITS-1:0] angle_x,
  input  logic signed [ANGLE_BITS-1:0] angle_y,
  input  logic signed [ANGLE_BITS-1:0] angle_z,
  output logic                        matrix_valid,
  input  logic                        matrix_stall,
  output logic signed [FRAC_BITS+1:0] m00,
  output logic signed [FRAC_BITS+1:0] m01,
  output logic signed [FRAC_BITS+1:0] m02,
  output logic signed [FRAC_BITS+1:0] m10,
  output logic signed [FRAC_BITS+1:0] m11,
  output logic signed [FRAC_BITS+1:0] m12,
  output logic signed [FRAC_BITS+1:0] m20,
  output logic signed [FRAC_BITS+1:0] m21,
  output logic signed [FRAC_BITS+1:0] m22
);
  import erm_pkg::*;

  localparam int N = LANE_STAGES + MERGE_STAGES;

  logic [N-1:0]               v;
  logic [N-1:0]               en;
  sc_t                        scx;
  sc_t                        scy;
  sc_t                        scz;
  logic signed [FRAC_BITS+1:0] m [9];

  always_comb begin
    en[N-1] = !v[N-1] || !matrix_stall;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= angle_valid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  erm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_lane_x (
    .clk(clk), .en(en[LANE_STAGES-1:0]), .angle(angle_x), .sc(scx)
  );
  erm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_lane_y (
    .clk(clk), .en(en[LANE_STAGES-1:0]), .angle(angle_y), .sc(scy)
  );
  erm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_lane_z (
    .clk(clk), .en(en[LANE_STAGES-1:0]), .angle(angle_z), .sc(scz)
  );

  erm_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk(clk), .en(en[N-1:LANE_STAGES]), .scx(scx), .scy(scy), .scz(scz), .m(m)
  );

  assign angle_stall  = !en[0];
  assign matrix_valid = v[N-1];
  assign m00 = m[0];
  assign m01 = m[1];
  assign m02 = m[2];
  assign m10 = m[3];
  assign m11 = m[4];
  assign m12 = m[5];
  assign m20 = m[6];
  assign m21 = m[7];
  assign m22 = m[8];

endmodule

/* hw/rtl/erm_checker.sv */
// Port-level checks for the rotation matrix block, bound to the top level.
// Depends on euler_rotation_matrix_top_assert.svh.
module erm_checker #(
  parameter int FRAC_BITS = 14
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        angle_stall,
  input logic                        matrix_valid,
  input logic                        matrix_stall,
  input logic signed [FRAC_BITS+1:0] m00,
  input logic signed [FRAC_BITS+1:0] m20,
  input logic signed [FRAC_BITS+1:0] m22
);
`include "euler_rotation_matrix_top_assert.svh"

  localparam int LIM = 1 << FRAC_BITS;

  logic range_ok;

  assign range_ok = m00 <= LIM && m00 >= -LIM && m20 <= LIM && m20 >= -LIM &&
                    m22 <= LIM && m22 >= -LIM;

  `ERM_ASSERT_ALWAYS(a_reset_empty, rst |=> !matrix_valid)
  `ERM_ASSERT(a_hold_beat, matrix_valid && matrix_stall |=> matrix_valid && $stable(m00))
  `ERM_ASSERT(a_stall_full, angle_stall |-> matrix_valid && matrix_stall)
  `ERM_ASSERT(a_range, matrix_valid |-> range_ok)

endmodule

bind euler_rotation_matrix_top erm_checker #(.FRAC_BITS(FRAC_BITS)) u_erm_checker (.*);

/* bench/tb_euler_rotation_matrix_top.sv */
// Testbench for the Euler-angle (ZYX) rotation matrix block.
// Needs euler_rotation_matrix_top and erm_pkg; predicts each matrix in fixed point.
`timescale 1ns / 100ps

module tb_euler_rotation_matrix_top;

  localparam int LATENCY = 28;

  typedef struct {
    logic signed [15:0] e [9];
  } matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic angle_valid = 1'b0;
  logic angle_stall;
  logic signed [15:0] angle_x = '0;
  logic signed [15:0] angle_y = '0;
  logic signed [15:0] angle_z = '0;
  logic matrix_valid;
  logic matrix_stall = 1'b0;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  matrix_t expected_matrices[$];
  int errors = 0;
  bit calm = 1'b0;

  euler_rotation_matrix_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint fx_mul(longint a, longint b);
    bit neg;
    longint unsigned ma, mb, m;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = (ma * mb + (64'd1 << 30)) >> 31;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  task automatic sine_cosine(input logic [15:0] ang, output longint s_o, output longint c_o);
    logic [31:0] p;
    logic [1:0] quad;
    logic [31:0] r;
    bit swap;
    longint unsigned x, x2, ts, tc, ds, dc;
    longint s, c, t;
    p = {ang, 16'h0};
    quad = p[31:30];
    r = {2'b0, p[29:0]};
    swap = r >= 32'h2000_0000;
    if (swap) r = 32'h4000_0000 - r;
    x = (64'(r) * 64'd3373259426 + (64'd1 << 29)) >> 30;
    x2 = (x * x + (64'd1 << 30)) >> 31;
    ts = x;
    tc = 64'd1 << 31;
    s = ts;
    c = tc;
    for (int k = 1; k <= 7; k++) begin
      ds = 64'(2 * k) * 64'(2 * k + 1);
      dc = 64'(2 * k - 1) * 64'(2 * k);
      ts = (ts * x2 + (64'd1 << 30)) >> 31;
      ts = (ts + ds / 2) / ds;
      tc = (tc * x2 + (64'd1 << 30)) >> 31;
      tc = (tc + dc / 2) / dc;
      if (k % 2) begin
        s -= longint'(ts);
        c -= longint'(tc);
      end else begin
        s += longint'(ts);
        c += longint'(tc);
      end
    end
    if (s < 0) s = 0;
    if (s > (64'sd1 << 31)) s = 64'sd1 << 31;
    if (c < 0) c = 0;
    if (c > (64'sd1 << 31)) c = 64'sd1 << 31;
    if (swap) begin
      t = s; s = c; c = t;
    end
    case (quad)
      2'd1: begin s_o = c; c_o = -s; end
      2'd2: begin s_o = -s; c_o = -c; end
      2'd3: begin s_o = -c; c_o = s; end
      default: begin s_o = s; c_o = c; end
    endcase
  endtask

  function automatic logic signed [15:0] to_q14(longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << 16)) >> 17;
    if (m > 16384) m = 16384;
    return (v < 0) ? -16'(m) : 16'(m);
  endfunction

  task automatic predict_matrix(input logic [15:0] ax, ay, az, output matrix_t mat);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    longint e [9];
    sine_cosine(ax, sx, cx);
    sine_cosine(ay, sy, cy);
    sine_cosine(az, sz, cz);
    sxsy = fx_mul(sx, sy);
    cxsy = fx_mul(cx, sy);
    e[0] = fx_mul(cy, cz);
    e[1] = fx_mul(sxsy, cz) - fx_mul(cx, sz);
    e[2] = fx_mul(cxsy, cz) + fx_mul(sx, sz);
    e[3] = fx_mul(cy, sz);
    e[4] = fx_mul(sxsy, sz) + fx_mul(cx, cz);
    e[5] = fx_mul(cxsy, sz) - fx_mul(sx, cz);
    e[6] = -sy;
    e[7] = fx_mul(sx, cy);
    e[8] = fx_mul(cx, cy);
    for (int i = 0; i < 9; i++) mat.e[i] = to_q14(e[i]);
  endtask

  task automatic send_angles(input logic [15:0] ax, ay, az);
    matrix_t mat;
    if (!calm && $urandom_range(99) < 18) begin
      angle_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 18);
    end
    predict_matrix(ax, ay, az, mat);
    angle_valid <= 1'b1;
    angle_x <= ax;
    angle_y <= ay;
    angle_z <= az;
    expected_matrices.push_back(mat);
    do @(posedge clk); while (angle_stall);
  endtask

  task automatic drain();
    angle_valid <= 1'b0;
    while (expected_matrices.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) matrix_stall <= 1'b0;
    else matrix_stall <= !calm && ($urandom_range(99) < 18);
  end

  always @(posedge clk) begin
    matrix_t got, want;
    if (!rst && matrix_valid && !matrix_stall) begin
      got.e = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
      if (expected_matrices.size() == 0) begin
        $display("%0t: matrix beat with none expected", $time);
        errors++;
      end else begin
        want = expected_matrices.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.e[i] !== want.e[i]) begin
            $display("%0t: m%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                     want.e[i], got.e[i]);
            errors++;
          end
      end
    end
  end

  task automatic test_directed();
    logic [15:0] edge_angles [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                     16'h7FFF, 16'h8001, 16'h2000, 16'hFFFF};
    for (int i = 0; i < 8; i++)
      send_angles(edge_angles[i], edge_angles[(i + 3) % 8], edge_angles[(i + 5) % 8]);
    send_angles(16'h2000, 16'h2000, 16'h2000);
    send_angles(16'h1FFF, 16'h6000, 16'hA000);
    send_angles(16'h5555, 16'hAAAA, 16'h3333);
    send_angles(16'h4000, 16'h4000, 16'h4000);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++)
      send_angles(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_near_quadrants(input int n);
    for (int i = 0; i < n; i++)
      send_angles({2'($urandom_range(3)), 14'd0} + 16'($urandom_range(8) - 4),
                  {3'($urandom_range(7)), 13'd0} + 16'($urandom_range(8) - 4),
                  16'($urandom));
  endtask

  task automatic test_back_to_back(input int n);
    calm = 1'b1;
    test_random(n);
    drain();
    calm = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();
    test_random(500);
    test_back_to_back(250);
    test_near_quadrants(200);
    test_random(190);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_matrices.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
